// ===== hdl/p2u_pkg.sv =====
// Package for the posit32 (es = 2) to uint32 converter.
// Holds the classification codes and the range limits; no dependencies.
package p2u_pkg;

  localparam int unsigned PositW = 32;
  localparam int unsigned UintW  = 32;

  // Input patterns that bound the directly answered ranges.
  localparam logic [PositW-1:0] NarPattern = 32'h8000_0000;
  localparam logic [PositW-1:0] HalfLimit  = 32'h3800_0000;
  localparam logic [PositW-1:0] OneLimit   = 32'h4400_0000;
  localparam logic [PositW-1:0] TwoLimit   = 32'h4A00_0000;
  localparam logic [PositW-1:0] SatLimit   = 32'h7FBF_FFFF;

  localparam logic [UintW-1:0] SatValue = 32'hFFFF_FFFF;
  localparam logic [UintW-1:0] NarValue = 32'h8000_0000;

  // How the final result is chosen: decoded and rounded, or a fixed answer.
  typedef enum logic [2:0] {
    SPC_NONE,
    SPC_ZERO,
    SPC_ONE,
    SPC_TWO,
    SPC_NAR,
    SPC_SAT
  } spc_t;

endpackage

// ===== hdl/p2u_in_if.sv =====
// Input channel of the converter: one posit pattern per transfer.
// Valid/ready handshake; no dependencies.
interface p2u_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] posit_bits;

  modport source (output valid, output posit_bits, input ready);
  modport sink (input valid, input posit_bits, output ready);
endinterface

// ===== hdl/p2u_out_if.sv =====
// Result channel of the converter: one unsigned integer per transfer.
// Valid/ready handshake; no dependencies.
interface p2u_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] uint_value;

  modport source (output valid, output uint_value, input ready);
  modport sink (input valid, input uint_value, output ready);
endinterface

// ===== hdl/posit32_to_uint32.sv =====
// Top level of the posit32 (es = 2) to uint32 converter.
// Depends on p2u_pkg, p2u_in_if and p2u_out_if.
//
// Usage: a 32-bit posit pattern arrives on in_ch and the rounded unsigned
// integer leaves on out_ch, one result for every input transfer, in order.
// Both channels use valid/ready; a transfer happens on a rising clock edge
// where both are high. Rounding is to nearest with ties to even. NaR passes
// through as 0x80000000, negative posits give 0, and values beyond 32 bits
// saturate to 0xFFFFFFFF.
//
// The result of an input transfer shows valid on out_ch once it has passed
// through the four register stages (classify and regime count, field
// extract and scale, alignment shift, rounding add into the output
// register). The pipe takes one item per cycle while the receiver does
// not stall.
//
// Every stage has its own valid bit and moves forward when the stage after
// it is empty or moving, so bubbles are squeezed out and in_ch.ready stays
// high while there is room anywhere in the pipe. When the receiver stalls,
// the output register holds its result and the stages behind it fill up;
// nothing is dropped or repeated. Reset (rst_n low, synchronous) empties all
// stages and holds in_ch.ready low; the block keeps no other state.
module posit32_to_uint32 (
  input logic      clk,
  input logic      rst_n,
  p2u_in_if.sink   in_ch,
  p2u_out_if.source out_ch
);
  import p2u_pkg::*;

  // Stage valid bits and per-stage advance conditions.
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_fire;

  // Stage 1: pattern, classification, regime run length.
  logic [PositW-1:0] p1_r;
  spc_t              spc1_r, spc1_nxt;
  logic [2:0]        k1_r, k1_nxt;

  // Stage 2: significand with hidden bit, and the binary scale.
  logic [28:0] m2_r, m2_nxt;
  logic [4:0]  scale2_r, scale2_nxt;
  spc_t        spc2_r;

  // Stage 3: integer part and rounding bits after alignment.
  logic [UintW-1:0] ipart3_r, ipart3_nxt;
  logic             guard3_r, guard3_nxt;
  logic             sticky3_r, sticky3_nxt;
  spc_t             spc3_r;

  // Stage 4: output register.
  logic [UintW-1:0] uint_r, uint_nxt;

  // Handshake: a stage takes new data when it is empty or being drained.
  // The input is refused while reset is held, since the first stage is
  // being emptied then.
  assign rdy4    = !out_valid_r || out_ch.ready;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign in_ch.ready = rdy1 && rst_n;
  assign in_fire = in_ch.valid && rdy1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.uint_value = uint_r;

  // Stage 1 logic: sort out the directly answered ranges and count the run
  // of ones that starts just below the leading regime bit. In the decoded
  // range the run is at most seven long.
  always_comb begin
    logic found_zero;
    found_zero = 1'b0;
    k1_nxt     = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (!found_zero && in_ch.posit_bits[29-i]) begin
        k1_nxt = k1_nxt + 3'd1;
      end else begin
        found_zero = 1'b1;
      end
    end

    if (in_ch.posit_bits == NarPattern) begin
      spc1_nxt = SPC_NAR;
    end else if (in_ch.posit_bits[31]) begin
      spc1_nxt = SPC_ZERO;
    end else if (in_ch.posit_bits <= HalfLimit) begin
      spc1_nxt = SPC_ZERO;
    end else if (in_ch.posit_bits < OneLimit) begin
      spc1_nxt = SPC_ONE;
    end else if (in_ch.posit_bits <= TwoLimit) begin
      spc1_nxt = SPC_TWO;
    end else if (in_ch.posit_bits > SatLimit) begin
      spc1_nxt = SPC_SAT;
    end else begin
      spc1_nxt = SPC_NONE;
    end
  end

  // Stage 2 logic: drop the run and its terminator, then read the two
  // exponent bits and the fraction. Each regime step is worth four.
  always_comb begin
    logic [29:0] body;
    logic [3:0]  shamt;
    shamt      = {1'b0, k1_r} + 4'd1;
    body       = p1_r[29:0] << shamt;
    m2_nxt     = {1'b1, body[27:0]};
    scale2_nxt = {k1_r, 2'b00} + {3'b000, body[29:28]};
  end

  // Stage 3 logic: the hidden bit has weight 2^28 before scaling, so after
  // shifting left by the scale the integer sits above bit 28.
  always_comb begin
    logic [59:0] aligned;
    aligned     = {31'd0, m2_r} << scale2_r;
    ipart3_nxt  = aligned[59:28];
    guard3_nxt  = aligned[27];
    sticky3_nxt = |aligned[26:0];
  end

  // Stage 4 logic: round to nearest, ties to even, or pick a fixed answer.
  // The increment cannot carry out: a set guard bit means a scale of at most
  // 27, so the integer part is far below 2^32.
  always_comb begin
    unique case (spc3_r)
      SPC_NONE: uint_nxt = ipart3_r
                           + {31'd0, guard3_r && (ipart3_r[0] || sticky3_r)};
      SPC_ZERO: uint_nxt = '0;
      SPC_ONE:  uint_nxt = 32'd1;
      SPC_TWO:  uint_nxt = 32'd2;
      SPC_NAR:  uint_nxt = NarValue;
      SPC_SAT:  uint_nxt = SatValue;
      default:  uint_nxt = '0;
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_ch.valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  // Payload registers move with their stage and need no reset.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_r   <= in_ch.posit_bits;
      spc1_r <= spc1_nxt;
      k1_r   <= k1_nxt;
    end
    if (rdy2) begin
      m2_r     <= m2_nxt;
      scale2_r <= scale2_nxt;
      spc2_r   <= spc1_r;
    end
    if (rdy3) begin
      ipart3_r  <= ipart3_nxt;
      guard3_r  <= guard3_nxt;
      sticky3_r <= sticky3_nxt;
      spc3_r    <= spc2_r;
    end
    if (rdy4) begin
      uint_r <= uint_nxt;
    end
  end

  // An accepted item always lands in the first stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v1_r)
    else $error("accepted item did not enter stage 1");

  // An item leaving stage 3 always reaches the output register.
  a_out_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4) |=> out_valid_r)
    else $error("item from stage 3 did not reach the output");

  // The decoded significand always carries its hidden bit.
  a_hidden_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && spc2_r == SPC_NONE) |-> m2_r[28])
    else $error("hidden bit missing in stage 2");

  // Rounding only happens on small integers, so the increment never wraps.
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && spc3_r == SPC_NONE && guard3_r) |-> (ipart3_r[31:29] == 3'b000))
    else $error("round-up requested on a large integer part");

endmodule
